FILE: rtl/core/assert_macros.svh
// assertion macros used by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define VWMF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("vwmf assertion failed");

// condition must never be true outside reset
`define VWMF_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("vwmf forbidden condition seen");

`else

`define VWMF_ASSERT(lbl, clk, rstn, prop)
`define VWMF_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: rtl/core/vwmf_pkg.sv
// shared types and constants of the valid window median filter
package vwmf_pkg;

    localparam int WINDOW    = 5;
    localparam int DIST_W    = 10;
    localparam int VCNT_W    = 5;
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ROT_W     = $clog2(WINDOW + 1);
    localparam int CFG_IDX_W = 4;

    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [VCNT_W-1:0] vcnt_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam dist_t NO_VALID_CODE = dist_t'(999);
    localparam dist_t MIN_RESET     = dist_t'(2);
    localparam dist_t MAX_RESET     = dist_t'(300);

    localparam cfg_idx_t REG_MIN_VALID = cfg_idx_t'(0);
    localparam cfg_idx_t REG_MAX_VALID = cfg_idx_t'(1);

    // value circulating around the ring during ranking
    typedef struct packed {
        logic  ok;
        idx_t  idx;
        dist_t val;
    } probe_t;

    // result travelling down the select chain
    typedef struct packed {
        logic  found;
        dist_t val;
    } sel_t;

    localparam sel_t SEL_NONE = '{found: 1'b0, val: '0};

    // per-cycle commands to every cell
    typedef struct packed {
        logic shift;
        logic load;
        logic rot;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROT,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/core/vwmf_cell.sv
// one window cell: holds a reading, ranks it against the circulating probes
module vwmf_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  vwmf_pkg::cell_ctl_t ctl,
    input  vwmf_pkg::dist_t     min_valid,
    input  vwmf_pkg::dist_t     max_valid,
    input  vwmf_pkg::idx_t      my_idx,
    input  vwmf_pkg::dist_t     sample_in,
    input  logic                occ_in,
    input  vwmf_pkg::probe_t    probe_in,
    input  vwmf_pkg::vcnt_t     target_rank,
    input  vwmf_pkg::sel_t      sel_in,
    output vwmf_pkg::dist_t     sample_out,
    output logic                occ_out,
    output vwmf_pkg::probe_t    probe_out,
    output vwmf_pkg::sel_t      sel_out
);
    import vwmf_pkg::*;

    dist_t  sample_reg;
    logic   occ_reg;
    probe_t probe_reg;
    vcnt_t  rank_reg;

    logic own_ok;
    logic beats;

    assign own_ok = occ_reg && (sample_reg >= min_valid) && (sample_reg <= max_valid);

    // probe ranks below this cell; equal values broken by cell position
    assign beats = probe_reg.ok &&
                   ((probe_reg.val < sample_reg) ||
                    ((probe_reg.val == sample_reg) && (probe_reg.idx < my_idx)));

    // probe index and value need no reset, only the ok flag does
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= 1'b0;
            probe_reg.ok <= 1'b0;
            rank_reg     <= '0;
        end else begin
            if (ctl.shift) begin
                occ_reg <= occ_in;
            end
            if (ctl.load) begin
                probe_reg <= '{ok: own_ok, idx: my_idx, val: sample_reg};
                rank_reg  <= '0;
            end else if (ctl.rot) begin
                probe_reg <= probe_in;
                if (beats) begin
                    rank_reg <= rank_reg + vcnt_t'(1);
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            sample_reg <= sample_in;
        end
    end

    always_comb begin
        if (sel_in.found) begin
            sel_out = sel_in;
        end else if (own_ok && (rank_reg == target_rank)) begin
            sel_out = '{found: 1'b1, val: sample_reg};
        end else begin
            sel_out = sel_in;
        end
    end

    assign sample_out = sample_reg;
    assign occ_out    = occ_reg;
    assign probe_out  = probe_reg;

endmodule

FILE: rtl/core/valid_window_median_filter_top.sv
// top level: sliding window median of in-band distance readings, chain of window cells
// per item: load, probe rotation around the cell ring, then select into the output register once it is free
// a new item is taken only when idle, after the last one has finished ranking and loaded its result
// a finished result waits in the output register while the next item is taken
// reset (aresetn low, synchronous): window emptied, band back to 2..300, no result pending
`include "assert_macros.svh"

module valid_window_median_filter_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vwmf_pkg::dist_t      s_raw_distance,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output vwmf_pkg::dist_t      m_median_distance,
    output vwmf_pkg::vcnt_t      m_valid_count,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  vwmf_pkg::cfg_idx_t   cfg_index,
    input  vwmf_pkg::dist_t      cfg_data
);
    import vwmf_pkg::*;

    // valid band registers
    dist_t min_valid_reg;
    dist_t max_valid_reg;

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic [ROT_W-1:0] rot_reg;
    vcnt_t vcnt_reg;

    cell_ctl_t ctl;
    logic      out_load;
    logic      out_free;
    logic      rot_last;

    // output register
    logic  m_valid_reg;
    dist_t median_reg;
    vcnt_t count_reg;

    // cell chain wiring
    dist_t  sample_w [WINDOW];
    logic   occ_w    [WINDOW];
    probe_t probe_w  [WINDOW];
    sel_t   sel_w    [WINDOW];
    logic [WINDOW-1:0] occ_vec;

    vcnt_t target_rank;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_valid_reg <= MIN_RESET;
            max_valid_reg <= MAX_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_VALID: min_valid_reg <= cfg_data;
                REG_MAX_VALID: max_valid_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // median sits at rank count/2 among the in-band readings
    assign target_rank = vcnt_reg >> 1;

    // ring of cells: new reading enters cell 0 and the oldest falls off the far end,
    // probes circulate from the last cell back to cell 0
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        dist_t  sample_in_k;
        logic   occ_in_k;
        probe_t probe_in_k;
        sel_t   sel_in_k;

        if (k == 0) begin : g_head
            assign sample_in_k = s_raw_distance;
            assign occ_in_k    = 1'b1;
            assign probe_in_k  = probe_w[WINDOW-1];
            assign sel_in_k    = SEL_NONE;
        end else begin : g_body
            assign sample_in_k = sample_w[k-1];
            assign occ_in_k    = occ_w[k-1];
            assign probe_in_k  = probe_w[k-1];
            assign sel_in_k    = sel_w[k-1];
        end

        vwmf_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .min_valid   (min_valid_reg),
            .max_valid   (max_valid_reg),
            .my_idx      (idx_t'(k)),
            .sample_in   (sample_in_k),
            .occ_in      (occ_in_k),
            .probe_in    (probe_in_k),
            .target_rank (target_rank),
            .sel_in      (sel_in_k),
            .sample_out  (sample_w[k]),
            .occ_out     (occ_w[k]),
            .probe_out   (probe_w[k]),
            .sel_out     (sel_w[k])
        );

        assign occ_vec[k] = occ_w[k];
    end

    assign rot_last = (rot_reg == ROT_W'(WINDOW - 1));
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_ROT;
            ST_ROT: begin
                if (rot_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctl      = '0;
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ctl.shift = s_valid;
            end
            ST_LOAD: ctl.load = 1'b1;
            ST_ROT:  ctl.rot  = 1'b1;
            ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rot_reg   <= '0;
            vcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (ctl.load) begin
                rot_reg  <= '0;
                vcnt_reg <= '0;
            end else if (ctl.rot) begin
                rot_reg <= rot_reg + ROT_W'(1);
                // cell 0 sees every probe once per pass, so it tallies the in-band count
                if (probe_w[0].ok) begin
                    vcnt_reg <= vcnt_reg + vcnt_t'(1);
                end
            end
        end
    end

    // output register: loaded at the end of ranking, held until the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            median_reg <= (vcnt_reg == '0) ? NO_VALID_CODE : sel_w[WINDOW-1].val;
            count_reg  <= vcnt_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_median_distance = median_reg;
    assign m_valid_count     = count_reg;

    // occupied cells always form a run starting at cell 0
    `VWMF_ASSERT(a_occ_thermo, aclk, aresetn, (occ_vec & (occ_vec + WINDOW'(1))) == '0)
    // in-band count never exceeds the number of held readings
    `VWMF_ASSERT(a_cnt_le_fill, aclk, aresetn, (state_reg == ST_DONE) |-> (vcnt_reg <= vcnt_t'($countones(occ_vec))))
    // with any in-band reading, exactly the median rank is present in the chain
    `VWMF_ASSERT(a_sel_found, aclk, aresetn, ((state_reg == ST_DONE) && (vcnt_reg != '0)) |-> sel_w[WINDOW-1].found)
    // rotation pass ends after one lap of the ring
    `VWMF_ASSERT(a_rot_lap, aclk, aresetn, ((state_reg == ST_ROT) && rot_last) |=> (state_reg == ST_DONE))

endmodule

FILE: dv/vwmf_median_checker.sv
// checker for the valid window median filter: predicts each result and compares it
module vwmf_median_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  vwmf_pkg::dist_t    s_raw_distance,
    input  logic               m_valid,
    input  logic               m_ready,
    input  vwmf_pkg::dist_t    m_median_distance,
    input  vwmf_pkg::vcnt_t    m_valid_count,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  vwmf_pkg::cfg_idx_t cfg_index,
    input  vwmf_pkg::dist_t    cfg_data,
    output int                 fail_count,
    output int                 outstanding,
    output int                 checked_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vwmf_pkg::*;

    typedef struct packed {
        dist_t median;
        vcnt_t count;
    } median_result_t;

    median_result_t expected_medians[$];
    dist_t          ring [WINDOW];
    int             ring_slot;
    int             ring_fill;
    dist_t          band_lo;
    dist_t          band_hi;
    int             mismatches;
    int             compared;

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        checked_count = 0;
        mismatches    = 0;
        compared      = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // upper median of the in-band readings held so far
    function automatic median_result_t rank_window();
        dist_t          kept [WINDOW];
        dist_t          key;
        int             n;
        int             j;
        median_result_t r;
        n = 0;
        for (int i = 0; i < ring_fill; i++) begin
            if (ring[i] >= band_lo && ring[i] <= band_hi) begin
                kept[n] = ring[i];
                n++;
            end
        end
        if (n == 0) begin
            r.median = NO_VALID_CODE;
            r.count  = '0;
            return r;
        end
        for (int i = 1; i < n; i++) begin
            key = kept[i];
            j   = i;
            while (j > 0 && kept[j-1] > key) begin
                kept[j] = kept[j-1];
                j--;
            end
            kept[j] = key;
        end
        r.median = kept[n/2];
        r.count  = vcnt_t'(n);
        return r;
    endfunction

    always @(posedge aclk) begin
        median_result_t want;
        if (!aresetn) begin
            foreach (ring[i]) ring[i] = '0;
            ring_slot = 0;
            ring_fill = 0;
            band_lo   = MIN_RESET;
            band_hi   = MAX_RESET;
            expected_medians.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_VALID: band_lo = cfg_data;
                    REG_MAX_VALID: band_hi = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_medians.size() == 0) begin
                    report_mismatch($sformatf("unexpected result median=%0d count=%0d",
                                              m_median_distance, m_valid_count));
                end else begin
                    want = expected_medians.pop_front();
                    compared++;
                    if (m_median_distance !== want.median)
                        report_mismatch($sformatf("median_distance got %0d want %0d",
                                                  m_median_distance, want.median));
                    if (m_valid_count !== want.count)
                        report_mismatch($sformatf("valid_count got %0d want %0d",
                                                  m_valid_count, want.count));
                end
            end
            if (s_valid && s_ready) begin
                ring[ring_slot] = s_raw_distance;
                ring_slot = (ring_slot + 1) % WINDOW;
                if (ring_fill < WINDOW) ring_fill++;
                expected_medians.push_back(rank_window());
            end
        end
        fail_count    <= mismatches;
        outstanding   <= expected_medians.size();
        checked_count <= compared;
    end

endmodule

FILE: dv/valid_window_median_filter_top_tb.sv
// testbench top for the valid window median filter: stimulus, idling and verdict
module valid_window_median_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vwmf_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 400000;  // room for ~1700 items, several times over
    localparam int DRAIN_CYCLES  = 20;      // extra wait once no result is outstanding
    localparam int IDLE_PCT      = 18;
    localparam int PHASE_ITEMS   = 210;
    localparam int RANDOM_PHASES = 8;

    // indexes with no register behind them, writes there must change nothing
    localparam cfg_idx_t REG_UNUSED_LO = cfg_idx_t'(2);
    localparam cfg_idx_t REG_UNUSED_HI = cfg_idx_t'(15);

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    dist_t    s_raw_distance;
    logic     m_valid;
    logic     m_ready;
    dist_t    m_median_distance;
    vcnt_t    m_valid_count;
    logic     cfg_valid;
    logic     cfg_ready;
    cfg_idx_t cfg_index;
    dist_t    cfg_data;

    int       fail_count;
    int       outstanding;
    int       checked_count;

    // stimulus side copy of the band, only used to aim readings into the band and at its edges
    dist_t    band_lo;
    dist_t    band_hi;
    bit       sender_idles;
    bit       receiver_stalls;
    int       readings_sent;
    int       band_settings;
    int       cycles;

    always #(CLK_PERIOD/2) aclk = ~aclk;

    valid_window_median_filter_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_distance    (s_raw_distance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_median_distance (m_median_distance),
        .m_valid_count     (m_valid_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    vwmf_median_checker mon (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_distance    (s_raw_distance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_median_distance (m_median_distance),
        .m_valid_count     (m_valid_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .outstanding       (outstanding),
        .checked_count     (checked_count)
    );

    // cycle counter doubles as the watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure: while receiver_stalls is set, ready drops IDLE_PCT percent of the time
    always @(posedge aclk) begin
        if (receiver_stalls) begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one reading per transfer; idle cycles are drawn per cycle before valid goes up
    task automatic send_reading(input dist_t reading);
        if (sender_idles) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_raw_distance <= reading;
        do @(posedge aclk); while (!s_ready);
        readings_sent++;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input dist_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_band(input dist_t lo, input dist_t hi);
        write_reg(REG_MIN_VALID, lo);
        write_reg(REG_MAX_VALID, hi);
        band_lo = lo;
        band_hi = hi;
        band_settings++;
    endtask

    // readings inside the band or at and just beyond its edges about half the time, else no-echo codes or noise
    function automatic dist_t pick_reading();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35 && band_lo <= band_hi) begin
            return dist_t'($urandom_range(band_hi, band_lo));
        end else if (roll < 50) begin
            case ($urandom_range(3))
                0:       return band_lo;
                1:       return band_hi;
                2:       return band_lo - dist_t'(1);  // just under the band, wraps at zero
                default: return band_hi + dist_t'(1);  // just over the band, wraps at the top
            endcase
        end else if (roll < 58) begin
            return NO_VALID_CODE;
        end
        return dist_t'($urandom_range(1023));
    endfunction

    initial begin
        // every input known from time zero, reset held low before release
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_raw_distance  <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        m_ready         <= 1'b0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        readings_sent   = 0;
        band_settings   = 1;
        band_lo         = MIN_RESET;
        band_hi         = MAX_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default band 2..300: below min, both inclusive edges, above max, top of range,
        // no-echo code; the window fills, wraps and passes through even valid counts
        send_reading(dist_t'(0));
        send_reading(dist_t'(1));
        send_reading(MIN_RESET);
        send_reading(MAX_RESET);
        send_reading(MAX_RESET + dist_t'(1));
        send_reading(dist_t'(1023));
        send_reading(NO_VALID_CODE);
        send_reading(dist_t'(150));
        settle();

        // whole range valid, so the no-echo code itself becomes a reading
        set_band(dist_t'(0), dist_t'(1023));
        send_reading(dist_t'(1023));
        send_reading(dist_t'(0));
        send_reading(NO_VALID_CODE);
        send_reading(dist_t'(512));
        settle();

        // empty band: min above max, nothing can be valid
        set_band(dist_t'(500), dist_t'(400));
        send_reading(dist_t'(450));
        send_reading(dist_t'(300));
        settle();

        // single value band, then writes to unused indexes that must not move it
        set_band(NO_VALID_CODE, NO_VALID_CODE);
        write_reg(REG_UNUSED_LO, dist_t'(0));
        write_reg(REG_UNUSED_HI, dist_t'(1023));
        send_reading(NO_VALID_CODE);
        send_reading(NO_VALID_CODE - dist_t'(1));
        send_reading(NO_VALID_CODE + dist_t'(1));
        send_reading(NO_VALID_CODE);
        settle();

        // random phases, one band setting each
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_band(MIN_RESET, MAX_RESET);
                1: set_band(dist_t'(0), dist_t'(1023));
                2: set_band(dist_t'(0), dist_t'(0));
                3: set_band(dist_t'(1023), dist_t'(1023));
                4: set_band(dist_t'(100), dist_t'(900));
                5: set_band(dist_t'($urandom_range(511)), dist_t'($urandom_range(1023, 512)));
                6: set_band(dist_t'($urandom_range(1023, 512)), dist_t'($urandom_range(511)));
                default: begin
                    write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                              dist_t'($urandom_range(1023)));
                    set_band(dist_t'($urandom_range(1023)), dist_t'($urandom_range(1023)));
                end
            endcase
            // one long stretch with neither side idling
            sender_idles    = (p != 3);
            receiver_stalls = (p != 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // halfway through, hold the sender until the result queue runs dry
                if (k == PHASE_ITEMS/2) settle();
                send_reading(pick_reading());
            end
            settle();
        end

        $display("summary: %0d readings sent, %0d results checked across %0d band settings",
                 readings_sent, checked_count, band_settings);
        $display("summary: default, full, empty, inverted and single-value bands, window wrap");
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, outstanding);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/vwmf_pkg.sv
rtl/core/vwmf_cell.sv
rtl/core/valid_window_median_filter_top.sv
dv/vwmf_median_checker.sv
dv/valid_window_median_filter_top_tb.sv
